FILE: hw/rtl/ssa_pkg.sv
package ssa_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SEL_IDX_W = 13;

  localparam logic [31:0] PAGE_THRESHOLD = 32'h0010_0000;
  localparam logic [4:0] DATA_TYPE = 5'h13;
  localparam logic [1:0] DATA_DPL = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD_SEL = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_COUNT-1:0] mask_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] base_address;
    logic [31:0] segment_limit;
    logic [15:0] selector_in;
  } req_word_t;

  typedef struct packed {
    logic [15:0] selector_out;
    logic [63:0] descriptor;
    logic [1:0]  status;
  } rsp_word_t;

  typedef struct packed {
    logic  found;
    slot_t slot;
  } find_t;

  function automatic logic [63:0] build_descriptor(logic [31:0] base, logic [31:0] limit);
    logic        paged;
    logic [31:0] lim;
    paged = (limit >= PAGE_THRESHOLD);
    lim = paged ? (limit >> 12) : limit;
    return {base[31:24], paged, 1'b1, 1'b0, 1'b0, lim[19:16],
            1'b1, DATA_DPL, DATA_TYPE, base[23:0], lim[15:0]};
  endfunction

endpackage

FILE: hw/rtl/segment_selector_allocator_unit.sv
// A word accepted on req is registered in req_q, then its answer in rsp;
// both hold while rsp stalls. Throughput: one word per cycle unless rsp
// stalls; the free mask is read and updated in the result stage, so
// back-to-back words see each other's allocations.
// Reset (rst, synchronous, active high): all slots free, both stages empty.
module segment_selector_allocator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ssa_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ssa_pkg::rsp_word_t rsp
);

  logic                           req_q_valid;
  ssa_pkg::req_word_t             req_q;
  ssa_pkg::mask_t                 free_mask;
  ssa_pkg::mask_t                 free_mask_next;
  ssa_pkg::rsp_word_t             rsp_next;
  ssa_pkg::find_t                 find;
  logic                           advance;
  logic [ssa_pkg::SEL_IDX_W-1:0]  sel_idx;
  logic                           sel_ok;
  ssa_pkg::slot_t                 free_slot;

  assign advance = !rsp_valid || rsp_ready;
  assign req_ready = !req_q_valid || advance;

  ssa_slot_find u_slot_find (
    .free_mask (free_mask),
    .find      (find)
  );

  assign sel_idx = req_q.selector_in[15:3];
  assign sel_ok = (sel_idx != '0) &&
                  (sel_idx <= ssa_pkg::SEL_IDX_W'(ssa_pkg::SLOT_COUNT));
  assign free_slot = ssa_pkg::slot_t'(sel_idx - ssa_pkg::SEL_IDX_W'(1));

  always_comb begin
    free_mask_next = free_mask;
    rsp_next.selector_out = req_q.selector_in;
    rsp_next.descriptor = '0;
    rsp_next.status = ssa_pkg::STATUS_OK;
    if (req_q.cmd == ssa_pkg::CMD_ALLOC) begin
      if (find.found) begin
        free_mask_next[find.slot] = 1'b0;
        rsp_next.selector_out = 16'({find.slot, 3'b000}) + 16'd15;
        rsp_next.descriptor = ssa_pkg::build_descriptor(req_q.base_address,
                                                        req_q.segment_limit);
      end else begin
        rsp_next.selector_out = '0;
        rsp_next.status = ssa_pkg::STATUS_FULL;
      end
    end else begin
      if (sel_ok) begin
        free_mask_next[free_slot] = 1'b1;
      end else begin
        rsp_next.status = ssa_pkg::STATUS_BAD_SEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid <= 1'b0;
      free_mask <= '1;
    end else begin
      if (req_ready) begin
        req_q_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= req_q_valid;
      end
      if (req_q_valid && advance) begin
        free_mask <= free_mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (req_q_valid && advance) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_reset_all_free: assert property (@(posedge clk) rst |=> free_mask == '1)
    else $error("free mask not all ones after reset");

  a_alloc_takes_one: assert property (@(posedge clk) disable iff (rst)
    (req_q_valid && advance && req_q.cmd == ssa_pkg::CMD_ALLOC && find.found) |=>
    ($countones(free_mask) == $past($countones(free_mask)) - 1))
    else $error("allocate did not take exactly one slot");

  a_full_reported: assert property (@(posedge clk) disable iff (rst)
    (req_q_valid && advance && req_q.cmd == ssa_pkg::CMD_ALLOC && free_mask == '0) |=>
    (rsp_valid && rsp.status == ssa_pkg::STATUS_FULL))
    else $error("empty mask not reported as table full");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ssa_pkg::STATUS_FULL) |->
    (rsp.selector_out == '0 && rsp.descriptor == '0))
    else $error("table full word carries nonzero selector or descriptor");
`endif

endmodule

FILE: hw/rtl/ssa_slot_find.sv
module ssa_slot_find (
  input  ssa_pkg::mask_t free_mask,
  output ssa_pkg::find_t find
);

  always_comb begin
    find.found = |free_mask;
    find.slot = '0;
    for (int i = ssa_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        find.slot = ssa_pkg::slot_t'(i);
      end
    end
  end

endmodule

FILE: tb/sv/segment_selector_checker.sv
`timescale 1ns / 100ps

module segment_selector_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  ssa_pkg::req_word_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  ssa_pkg::rsp_word_t rsp,
  output int                 mismatch_count,
  output int                 pending_words,
  output int                 checked_words,
  output int                 full_answers,
  output int                 rejected_selectors,
  output int                 paged_limits
);

  ssa_pkg::mask_t     free_slots;
  ssa_pkg::rsp_word_t expected_rsp_q[$];

  initial begin
    mismatch_count     = 0;
    pending_words      = 0;
    checked_words      = 0;
    full_answers       = 0;
    rejected_selectors = 0;
    paged_limits       = 0;
    free_slots         = '1;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic logic [63:0] data_descriptor(logic [31:0] base, logic [31:0] limit);
    logic        paged;
    logic [19:0] lim20;
    logic [63:0] d;
    paged = (limit >= ssa_pkg::PAGE_THRESHOLD);
    lim20 = paged ? limit[31:12] : limit[19:0];
    d = '0;
    d[15:0]  = lim20[15:0];
    d[39:16] = base[23:0];
    d[44:40] = ssa_pkg::DATA_TYPE;
    d[46:45] = ssa_pkg::DATA_DPL;
    d[47]    = 1'b1;
    d[51:48] = lim20[19:16];
    d[54]    = 1'b1;
    d[55]    = paged;
    d[63:56] = base[31:24];
    return d;
  endfunction

  // applies one command to the slot table and returns the answer it gives
  task automatic apply_table_command(input ssa_pkg::req_word_t w,
                                     output ssa_pkg::rsp_word_t r);
    int slot;
    int idx;
    slot = -1;
    r = '0;
    if (w.cmd == ssa_pkg::CMD_ALLOC) begin
      for (int s = 0; s < ssa_pkg::SLOT_COUNT; s++) begin
        if (slot < 0 && free_slots[s]) slot = s;
      end
      if (slot < 0) begin
        r.status = ssa_pkg::STATUS_FULL;
        full_answers++;
      end else begin
        free_slots[slot] = 1'b0;
        r.selector_out = 16'(slot * 8 + 15);
        r.descriptor   = data_descriptor(w.base_address, w.segment_limit);
        r.status       = ssa_pkg::STATUS_OK;
        if (w.segment_limit >= ssa_pkg::PAGE_THRESHOLD) paged_limits++;
      end
    end else begin
      idx = int'(w.selector_in[15:3]);
      r.selector_out = w.selector_in;
      if (idx == 0 || idx - 1 >= ssa_pkg::SLOT_COUNT) begin
        r.status = ssa_pkg::STATUS_BAD_SEL;
        rejected_selectors++;
      end else begin
        free_slots[idx - 1] = 1'b1;
        r.status = ssa_pkg::STATUS_OK;
      end
    end
  endtask

  always @(posedge clk) begin
    ssa_pkg::rsp_word_t want;
    ssa_pkg::rsp_word_t predicted;
    if (rst) begin
      free_slots = '1;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response word", 64'(rsp), 64'd0);
        end else begin
          want = expected_rsp_q.pop_front();
          checked_words++;
          if (rsp.selector_out !== want.selector_out)
            report_mismatch("selector_out", 64'(rsp.selector_out), 64'(want.selector_out));
          if (rsp.descriptor !== want.descriptor)
            report_mismatch("descriptor", rsp.descriptor, want.descriptor);
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
        end
      end
      if (req_valid && req_ready) begin
        apply_table_command(req, predicted);
        expected_rsp_q.push_back(predicted);
      end
    end
    pending_words <= expected_rsp_q.size();
  end

endmodule

FILE: tb/sv/tb_segment_selector_allocator_unit.sv
`timescale 1ns / 100ps

module tb_segment_selector_allocator_unit;

  localparam int LIMIT_CYCLES   = 200000;
  localparam int PHASE_WORDS    = 430;
  localparam int CHUNK_WORDS    = 30;
  localparam int DRAIN_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  ssa_pkg::req_word_t req = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ssa_pkg::rsp_word_t rsp;

  int mismatch_count;
  int pending_words;
  int checked_words;
  int full_answers;
  int rejected_selectors;
  int paged_limits;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int alloc_sent    = 0;
  int free_sent     = 0;
  int cycle_count   = 0;

  segment_selector_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  segment_selector_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_ready          (req_ready),
    .req                (req),
    .rsp_valid          (rsp_valid),
    .rsp_ready          (rsp_ready),
    .rsp                (rsp),
    .mismatch_count     (mismatch_count),
    .pending_words      (pending_words),
    .checked_words      (checked_words),
    .full_answers       (full_answers),
    .rejected_selectors (rejected_selectors),
    .paged_limits       (paged_limits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_words);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input ssa_pkg::req_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    if (w.cmd == ssa_pkg::CMD_ALLOC) alloc_sent++;
    else free_sent++;
  endtask

  task automatic wait_until_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  function automatic ssa_pkg::req_word_t alloc_word(logic [31:0] base, logic [31:0] limit);
    ssa_pkg::req_word_t w;
    w = '0;
    w.cmd           = ssa_pkg::CMD_ALLOC;
    w.base_address  = base;
    w.segment_limit = limit;
    return w;
  endfunction

  function automatic ssa_pkg::req_word_t free_word(logic [15:0] sel);
    ssa_pkg::req_word_t w;
    w = '0;
    w.cmd         = ssa_pkg::CMD_FREE;
    w.selector_in = sel;
    return w;
  endfunction

  function automatic ssa_pkg::req_word_t random_word(int alloc_pct);
    ssa_pkg::req_word_t w;
    w.base_address = $urandom();
    case ($urandom_range(3))
      0: w.segment_limit = $urandom_range(32'h000F_FFFF, 0);
      1: w.segment_limit = 32'h000F_FFFF + 32'($urandom_range(1));
      default: w.segment_limit = $urandom();
    endcase
    if ($urandom_range(99) < 85)
      w.selector_in = {13'($urandom_range(ssa_pkg::SLOT_COUNT, 1)),
                       3'($urandom_range(7))};
    else
      w.selector_in = 16'($urandom());
    w.cmd = ($urandom_range(99) < alloc_pct) ? ssa_pkg::CMD_ALLOC : ssa_pkg::CMD_FREE;
    return w;
  endfunction

  initial begin
    int alloc_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 25;
    recv_idle_pct = 52;

    // field extremes, threshold edges, bad and odd selectors
    send_word(alloc_word(32'h0000_0000, 32'h0000_0000));
    send_word(alloc_word(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(alloc_word(32'h1234_5678, 32'h000F_FFFF));
    send_word(alloc_word(32'h89AB_CDEF, 32'h0010_0000));
    send_word(alloc_word(32'hA5A5_5A5A, 32'h0FFF_FFFF));
    send_word(free_word(16'h0000));
    send_word(free_word(16'h0007));
    send_word(free_word(16'hFFFF));
    send_word(free_word(16'h0108));
    send_word(free_word(16'h0100));
    send_word(free_word(16'h0100));
    send_word(free_word(16'h000F));
    send_word(free_word(16'h0008));
    send_word(alloc_word(32'h0000_FFFF, 32'h0000_0001));
    send_word(free_word(16'h0013));
    send_word(free_word(16'h0017));
    send_word(alloc_word(32'h5A5A_A5A5, 32'h8000_0000));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int chunk = 0; chunk < PHASE_WORDS / CHUNK_WORDS; chunk++) begin
        // pick fill-heavy, balanced or release-heavy stretches at random
        case ($urandom_range(2))
          0: alloc_pct = 90;
          1: alloc_pct = 50;
          default: alloc_pct = 15;
        endcase
        for (int k = 0; k < CHUNK_WORDS; k++) send_word(random_word(alloc_pct));
        if (phase == 0 && chunk == 5) wait_until_drained();
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d allocate, %0d free), checked %0d responses",
             alloc_sent + free_sent, alloc_sent, free_sent, checked_words);
    $display("table full %0d times, %0d selectors rejected, %0d page-granular limits",
             full_answers, rejected_selectors, paged_limits);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
